/* rtl/scmd_pkg.sv */
// ----------------------------------------------------------------------------
// scmd_pkg
// shared types and constants of the segment clearance block
// ----------------------------------------------------------------------------
package scmd_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned ProdW  = 50;
  localparam int unsigned DotW   = 51;
  localparam int unsigned LsqW   = 50;
  localparam int unsigned LenW   = 25;
  localparam int unsigned DirW   = 18;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned DirFrac = 16;
  localparam int unsigned NumW   = 42;
  localparam int unsigned CrsW   = 43;
  localparam int unsigned LatW   = 27;
  localparam int unsigned SqW    = 54;
  localparam int unsigned RemW   = 26;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegStartX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStartY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEndX   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegEndY   = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] clearance;
    logic              no_point_in_span;
  } out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic [LsqW-1:0]          l2;
    logic signed [DirW-1:0]   ux;
    logic signed [DirW-1:0]   uy;
    logic                     zero;
  } seg_t;

  typedef struct packed {
    logic            in_span;
    logic [LsqW-1:0] sq;
    logic            last;
  } qent_t;

endpackage

/* rtl/scmd_isqrt.sv */
// ----------------------------------------------------------------------------
// scmd_isqrt
// iterative integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module scmd_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scmd_pkg::LsqW-1:0]  rad_i,
  output logic                       done_o,
  output logic [scmd_pkg::LenW-1:0]  root_o
);
  import scmd_pkg::*;

  logic [LsqW-1:0] rad_q, rad_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [LenW-1:0] root_q, root_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [RemW+1:0] rem_s, trial;

  always_comb begin
    rem_s  = {rem_q, rad_q[LsqW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 5'(LenW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[LsqW-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem_d  = RemW'(rem_s - trial);
        root_d = {root_q[LenW-2:0], 1'b1};
      end else begin
        rem_d  = rem_s[RemW-1:0];
        root_d = {root_q[LenW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      root_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/scmd_seg.sv */
// ----------------------------------------------------------------------------
// scmd_seg
// segment registers and derived length and unit direction
// ----------------------------------------------------------------------------
module scmd_seg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [scmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scmd_pkg::CoordW-1:0]   cfg_data_i,
  output logic                          idle_o,
  output scmd_pkg::seg_t                seg_o
);
  import scmd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiff = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StSqs  = 3'd4;
  localparam logic [2:0] StSqw  = 3'd5;
  localparam logic [2:0] StDivs = 3'd6;
  localparam logic [2:0] StDiv  = 3'd7;

  logic [2:0] st_q;
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [DiffW-1:0]  dx_q, dy_q;
  logic [ProdW-1:0]         pxx_q, pyy_q;
  logic [LsqW-1:0]          l2_q;
  logic [LenW-1:0]          len_q;
  logic signed [DirW-1:0]   ux_q, uy_q;
  logic [NumW-1:0]          remx_q, remy_q, divs_q;
  logic [QuoW-1:0]          qx_q, qy_q;
  logic [4:0]               cnt_q;
  logic                     sq_done;
  logic [LenW-1:0]          sq_root;
  logic [DiffW-1:0]         adx, ady;
  logic signed [ProdW-1:0]  sqx, sqy;

  scmd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == StSqs),
    .rad_i   (l2_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign adx = dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q);
  assign ady = dy_q[DiffW-1] ? DiffW'(-dy_q) : DiffW'(dy_q);
  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      sx_q  <= '0;
      sy_q  <= '0;
      ex_q  <= '0;
      ey_q  <= '0;
      dx_q  <= '0;
      dy_q  <= '0;
      l2_q  <= '0;
      len_q <= '0;
      ux_q  <= '0;
      uy_q  <= '0;
      cnt_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (cfg_valid_i) begin
            unique case (cfg_index_i)
              RegStartX: sx_q <= cfg_data_i;
              RegStartY: sy_q <= cfg_data_i;
              RegEndX:   ex_q <= cfg_data_i;
              RegEndY:   ey_q <= cfg_data_i;
              default: ;
            endcase
            st_q <= StDiff;
          end
        end
        StDiff: begin
          dx_q <= DiffW'(ex_q) - DiffW'(sx_q);
          dy_q <= DiffW'(ey_q) - DiffW'(sy_q);
          st_q <= StMul;
        end
        StMul: begin
          pxx_q <= ProdW'(sqx);
          pyy_q <= ProdW'(sqy);
          st_q  <= StSum;
        end
        StSum: begin
          l2_q <= LsqW'(pxx_q + pyy_q);
          st_q <= StSqs;
        end
        StSqs: st_q <= StSqw;
        StSqw: begin
          if (sq_done) begin
            len_q <= sq_root;
            st_q  <= StDivs;
          end
        end
        StDivs: begin
          remx_q <= NumW'({adx, DirFrac'(0)}) + NumW'(len_q >> 1);
          remy_q <= NumW'({ady, DirFrac'(0)}) + NumW'(len_q >> 1);
          divs_q <= NumW'({len_q, DirFrac'(0)});
          qx_q   <= '0;
          qy_q   <= '0;
          cnt_q  <= 5'(DirFrac);
          st_q   <= StDiv;
        end
        StDiv: begin
          if (remx_q >= divs_q) begin
            remx_q <= remx_q - divs_q;
            qx_q   <= {qx_q[QuoW-2:0], 1'b1};
          end else begin
            qx_q   <= {qx_q[QuoW-2:0], 1'b0};
          end
          if (remy_q >= divs_q) begin
            remy_q <= remy_q - divs_q;
            qy_q   <= {qy_q[QuoW-2:0], 1'b1};
          end else begin
            qy_q   <= {qy_q[QuoW-2:0], 1'b0};
          end
          divs_q <= divs_q >> 1;
          if (cnt_q == '0) begin
            st_q <= StIdle;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: st_q <= StIdle;
      endcase
      if (st_q == StDiv && cnt_q == '0) begin
        if (len_q == '0) begin
          ux_q <= '0;
          uy_q <= '0;
        end else begin
          ux_q <= dx_q[DiffW-1] ? -$signed({1'b0, qx_q[QuoW-2:0], remx_q >= divs_q})
                                :  $signed({1'b0, qx_q[QuoW-2:0], remx_q >= divs_q});
          uy_q <= dy_q[DiffW-1] ? -$signed({1'b0, qy_q[QuoW-2:0], remy_q >= divs_q})
                                :  $signed({1'b0, qy_q[QuoW-2:0], remy_q >= divs_q});
        end
      end
    end
  end

  assign idle_o    = (st_q == StIdle);
  assign seg_o.sx  = sx_q;
  assign seg_o.sy  = sy_q;
  assign seg_o.dx  = dx_q;
  assign seg_o.dy  = dy_q;
  assign seg_o.l2  = l2_q;
  assign seg_o.ux  = ux_q;
  assign seg_o.uy  = uy_q;
  assign seg_o.zero = (len_q == '0);

endmodule

/* rtl/scmd_front.sv */
// ----------------------------------------------------------------------------
// scmd_front
// point intake: span test and squared lateral distance, four stages
// ----------------------------------------------------------------------------
module scmd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  scmd_pkg::in_t   in_data_i,
  input  scmd_pkg::seg_t  seg_i,
  output logic            push_o,
  output scmd_pkg::qent_t push_data_o,
  input  logic            full_i
);
  import scmd_pkg::*;

  logic adv, take;
  logic v1_q, v2_q, v3_q, v4_q;
  logic l1_q, l2_q, l3_q, l4_q;
  logic signed [DiffW-1:0] rx_q, ry_q;
  logic signed [ProdW-1:0] mdx_q, mdy_q;
  logic signed [CrsW-1:0]  cx_q, cy_q;
  logic signed [DotW-1:0]  dot;
  logic signed [CrsW-1:0]  crs;
  logic [CrsW-1:0]         mag;
  logic [LatW-1:0]         lat_q;
  logic                    sp3_q, sp4_q;
  logic [SqW-1:0]          sq;
  logic [LsqW-1:0]         sq4_q;

  assign adv  = !v4_q || !full_i;
  assign take = in_valid_i && in_ready_o;
  assign in_ready_o = adv && en_i;

  assign dot = DotW'(mdx_q) + DotW'(mdy_q);
  assign crs = cx_q - cy_q;
  assign mag = crs[CrsW-1] ? CrsW'(-crs) : CrsW'(crs);
  assign sq  = SqW'(lat_q) * SqW'(lat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= take;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q  <= DiffW'(in_data_i.point_x) - DiffW'(seg_i.sx);
      ry_q  <= DiffW'(in_data_i.point_y) - DiffW'(seg_i.sy);
      l1_q  <= in_data_i.last_point;
      mdx_q <= seg_i.dx * rx_q;
      mdy_q <= seg_i.dy * ry_q;
      cx_q  <= seg_i.ux * ry_q;
      cy_q  <= seg_i.uy * rx_q;
      l2_q  <= l1_q;
      sp3_q <= !seg_i.zero && !dot[DotW-1] && (dot <= $signed({1'b0, seg_i.l2}));
      lat_q <= LatW'((mag + CrsW'(1 << (DirFrac - 1))) >> DirFrac);
      l3_q  <= l2_q;
      sp4_q <= sp3_q;
      sq4_q <= (|sq[SqW-1:LsqW]) ? '1 : sq[LsqW-1:0];
      l4_q  <= l3_q;
    end
  end

  assign push_o              = v4_q && !full_i;
  assign push_data_o.in_span = sp4_q;
  assign push_data_o.sq      = sq4_q;
  assign push_data_o.last    = l4_q;

endmodule

/* rtl/scmd_fifo.sv */
// ----------------------------------------------------------------------------
// scmd_fifo
// short queue between point intake and minimum tracking
// ----------------------------------------------------------------------------
module scmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  scmd_pkg::qent_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output scmd_pkg::qent_t pop_data_o
);
  import scmd_pkg::*;

  qent_t      mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  assign full_o     = cnt_q[2];
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rp_q];

endmodule

/* rtl/scmd_back.sv */
// ----------------------------------------------------------------------------
// scmd_back
// running minimum per point set and final root with output register
// ----------------------------------------------------------------------------
module scmd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  scmd_pkg::qent_t data_i,
  output logic            pop_o,
  input  logic            seg_zero_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output scmd_pkg::out_t  out_data_o
);
  import scmd_pkg::*;

  logic [LsqW-1:0] min_q, cur_min, new_min;
  logic            any_q, cur_any, new_any;
  logic            started_q, busy_q, rdy_q, anyf_q, ov_q;
  logic            sq_done, load;
  logic [LenW-1:0] root;
  out_t            od_q;

  assign pop_o   = valid_i && !busy_q;
  assign cur_min = started_q ? min_q : '1;
  assign cur_any = started_q && any_q;
  assign new_min = (data_i.in_span && data_i.sq < cur_min) ? data_i.sq : cur_min;
  assign new_any = cur_any || data_i.in_span;
  assign load    = rdy_q && (!ov_q || out_ready_i);

  scmd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop_o && data_i.last),
    .rad_i   (new_min),
    .done_o  (sq_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '1;
      any_q     <= 1'b0;
      started_q <= 1'b0;
      busy_q    <= 1'b0;
      rdy_q     <= 1'b0;
      anyf_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        min_q     <= new_min;
        any_q     <= new_any;
        started_q <= !data_i.last;
        if (data_i.last) begin
          busy_q <= 1'b1;
          anyf_q <= new_any;
        end
      end
      if (sq_done) rdy_q <= 1'b1;
      if (load) begin
        rdy_q  <= 1'b0;
        busy_q <= 1'b0;
        ov_q   <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      priority if (seg_zero_i) begin
        od_q.clearance        <= '0;
        od_q.no_point_in_span <= 1'b0;
      end else if (!anyf_q) begin
        od_q.clearance        <= '1;
        od_q.no_point_in_span <= 1'b1;
      end else begin
        od_q.clearance        <= root[LenW-1] ? '1 : root[CoordW-1:0];
        od_q.no_point_in_span <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

/* rtl/segment_clearance_min_distance.sv */
// ----------------------------------------------------------------------------
// segment_clearance_min_distance
// minimum lateral clearance between a line segment and a point stream
// ----------------------------------------------------------------------------
// cfg channel writes the segment end points (index 0..3: start x/y, end x/y);
// each write recomputes length and unit direction, during
// which cfg_ready_o and in_ready_o are low
// in channel takes one point per cycle unless stalled; a point set ends with
// last_point; out channel gives one result per point set: clearance and a
// no-point flag; a last point reaches its result through four intake stages,
// the queue, one minimum update and the root iteration
// points that are not last go through at one per cycle; after a last point
// the minimum stage waits for the root and the output register to free up,
// so the next set is held in the queue and then at the intake
// a stalled receiver holds the result in the output register; intake keeps
// running until the four-entry queue fills
// reset clears the segment to zero length and discards any open point set
// ----------------------------------------------------------------------------
module segment_clearance_min_distance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [scmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scmd_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  scmd_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output scmd_pkg::out_t                out_data_o
);
  import scmd_pkg::*;

  seg_t  seg;
  logic  seg_idle, push, full, pop, qvalid;
  qent_t push_data, pop_data;

  scmd_seg u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .idle_o      (seg_idle),
    .seg_o       (seg)
  );

  assign cfg_ready_o = seg_idle;

  scmd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (seg_idle),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .seg_i       (seg),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  scmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_data)
  );

  scmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (qvalid),
    .data_i      (pop_data),
    .pop_o       (pop),
    .seg_zero_i  (seg.zero),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/segment_clearance_min_distance_checker.sv */
// ----------------------------------------------------------------------------
// segment_clearance_min_distance_checker
// watches all channels, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_clearance_min_distance_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [scmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scmd_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  scmd_pkg::in_t                 in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  scmd_pkg::out_t                out_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_o
);
  import scmd_pkg::*;

  localparam longint unsigned SqCap = (64'd1 << 50) - 1;
  localparam longint unsigned ClrMax = (64'd1 << 24) - 1;

  logic signed [CoordW-1:0] seg_reg [4];
  longint seg_dx, seg_dy, seg_len_sq, dir_x, dir_y;
  longint unsigned seg_len, min_sq;
  logic any_hit, set_open;
  out_t expected_clearance_q [$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint scale_to_unit(longint d, longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q = ((mag << DirFrac) + (len >> 1)) / len;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void update_segment();
    seg_dx = longint'(seg_reg[RegEndX]) - longint'(seg_reg[RegStartX]);
    seg_dy = longint'(seg_reg[RegEndY]) - longint'(seg_reg[RegStartY]);
    seg_len_sq = seg_dx * seg_dx + seg_dy * seg_dy;
    seg_len = root_floor(seg_len_sq);
    if (seg_len == 0) begin
      dir_x = 0;
      dir_y = 0;
    end else begin
      dir_x = scale_to_unit(seg_dx, seg_len);
      dir_y = scale_to_unit(seg_dy, seg_len);
    end
  endfunction

  function automatic void track_point(in_t p);
    longint rx, ry, dot, crs;
    longint unsigned mag, lat, sq, c;
    out_t r;
    rx = longint'($signed(p.point_x)) - longint'(seg_reg[RegStartX]);
    ry = longint'($signed(p.point_y)) - longint'(seg_reg[RegStartY]);
    if (!set_open) begin
      min_sq = SqCap;
      any_hit = 1'b0;
      set_open = 1'b1;
    end
    if (seg_len != 0) begin
      dot = seg_dx * rx + seg_dy * ry;
      if (dot >= 0 && dot <= seg_len_sq) begin
        crs = dir_x * ry - dir_y * rx;
        mag = (crs < 0) ? -crs : crs;
        lat = (mag + (64'd1 << (DirFrac - 1))) >> DirFrac;
        sq = lat * lat;
        if (sq > SqCap) sq = SqCap;
        any_hit = 1'b1;
        if (sq < min_sq) min_sq = sq;
      end
    end
    if (p.last_point) begin
      if (seg_len == 0) begin
        r.clearance = '0;
        r.no_point_in_span = 1'b0;
      end else if (!any_hit) begin
        r.clearance = CoordW'(ClrMax);
        r.no_point_in_span = 1'b1;
      end else begin
        c = root_floor(min_sq);
        r.clearance = CoordW'((c > ClrMax) ? ClrMax : c);
        r.no_point_in_span = 1'b0;
      end
      expected_clearance_q.push_back(r);
      set_open = 1'b0;
    end
  endfunction

  assign pending_o = expected_clearance_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) seg_reg[i] = '0;
      min_sq = SqCap;
      any_hit = 1'b0;
      set_open = 1'b0;
      expected_clearance_q.delete();
      fail_count_o <= 0;
      results_o <= 0;
      update_segment();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        seg_reg[cfg_index_i] = cfg_data_i;
        update_segment();
      end
      if (in_valid_i && in_ready_i) track_point(in_data_i);
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (expected_clearance_q.size() == 0) begin
          $display("%0t: unexpected result clearance=%0d no_point=%0d", $time,
                   out_data_i.clearance, out_data_i.no_point_in_span);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_clearance_q.pop_front();
          if (want.clearance !== out_data_i.clearance ||
              want.no_point_in_span !== out_data_i.no_point_in_span) begin
            $display("%0t: mismatch expected clearance=%0d no_point=%0d, got %0d/%0d",
                     $time, want.clearance, want.no_point_in_span,
                     out_data_i.clearance, out_data_i.no_point_in_span);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/segment_clearance_min_distance_test.sv */
// ----------------------------------------------------------------------------
// segment_clearance_min_distance_test
// stimulus and verdict for the segment clearance block
// ----------------------------------------------------------------------------
// directed sets hit segment end points, out-of-span points, exact hits, empty
// spans, zero-length and extreme segments; random point sets follow, mostly
// placed along the segment, with random gaps, receiver stalls and backpressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_clearance_min_distance_test;
  import scmd_pkg::*;

  localparam int WatchLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int fail_count, pending, results;
  int points_sent, sets_sent, seg_settings, idle_cycles;
  int stall_req, stall_served;
  bit no_idle;
  longint seg_sx, seg_sy, seg_ex, seg_ey;

  always #5 clk_i = ~clk_i;

  segment_clearance_min_distance dut (.*);

  segment_clearance_min_distance_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver
  initial begin
    int r;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req != stall_served) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        stall_served = stall_req;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready_i <= 1'b1;
        end else if (r < 96) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(0, 3)) @(negedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(20, 60)) @(negedge clk_i);
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CoordW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic set_segment(longint sx, longint sy, longint ex, longint ey);
    drain();
    seg_sx = sx; seg_sy = sy; seg_ex = ex; seg_ey = ey;
    write_reg(RegStartX, sx);
    write_reg(RegStartY, sy);
    write_reg(RegEndX, ex);
    write_reg(RegEndY, ey);
    seg_settings++;
  endtask

  task automatic send_point(longint x, longint y, bit last);
    int g, r;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i.point_x <= x[CoordW-1:0];
    in_data_i.point_y <= y[CoordW-1:0];
    in_data_i.last_point <= last;
    do @(posedge clk_i); while (!in_ready_o);
    points_sent++;
    if (last) sets_sent++;
    r = $urandom_range(0, 99);
    g = (no_idle || r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 40);
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  function automatic longint near_point(bit along_x);
    longint k, off, s, e;
    s = along_x ? seg_sx : seg_sy;
    e = along_x ? seg_ex : seg_ey;
    k = $urandom_range(0, 1152);
    off = longint'($urandom_range(0, (1 << $urandom_range(0, 22)) - 1));
    if ($urandom_range(0, 1)) off = -off;
    return s + ((e - s) * (k - 64)) / 1024 + off;
  endfunction

  function automatic longint any_coord();
    return longint'($signed($urandom_range(0, (1 << CoordW) - 1) & 24'hffffff)) -
           (1 << (CoordW - 1));
  endfunction

  function automatic longint rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return any_coord();
    if (r < 15) return (r < 13) ? -8388608 : 8388607;
    return longint'($urandom_range(0, 40000)) - 20000;
  endfunction

  task automatic random_set();
    int n;
    bit near;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      near = $urandom_range(0, 99) < 85;
      send_point(near ? near_point(1) : any_coord(),
                 near ? near_point(0) : any_coord(), i == n - 1);
    end
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero-length segment straight out of reset
    send_point(123, 456, 1);

    set_segment(0, 0, 2560, 0);
    send_point(0, 100, 0);
    send_point(2560, -300, 0);
    send_point(2561, 0, 0);
    send_point(-1, 0, 0);
    send_point(1280, 0, 1);
    send_point(5000, 0, 1);
    send_point(8388607, 8388607, 0);
    send_point(-8388608, -8388608, 1);
    send_point(100, -8388608, 1);
    // segment change in the middle of a set
    send_point(100, 50, 0);
    drain();
    write_reg(RegEndX, 5120);
    seg_ex = 5120;
    send_point(4000, 70, 1);

    set_segment(-8388608, -8388608, 8388607, 8388607);
    send_point(0, 0, 0);
    send_point(8388607, -8388608, 1);
    set_segment(8388607, -8388608, -8388608, 8388607);
    send_point(-8388608, -8388608, 0);
    send_point(1, 1, 1);
    set_segment(5, 5, 5, 5);
    send_point(5, 5, 1);
    set_segment(0, 0, 0, -1);
    send_point(0, 0, 0);
    send_point(0, -1, 0);
    send_point(3, -1, 1);

    while (points_sent < 1750) begin
      if (sets_sent % 60 == 0) begin
        r = $urandom_range(0, 9);
        if (r == 0) set_segment(seg_sx, seg_sy, seg_sx, seg_sy);
        else if (r == 1)
          set_segment(rand_coord(), rand_coord(), seg_sx + $urandom_range(0, 2),
                      seg_sy - $urandom_range(0, 2));
        else set_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      if (sets_sent % 97 == 40) begin
        no_idle = 1'b1;
        if (stall_req == 0) stall_req = 1;
      end else if (sets_sent % 97 == 60) begin
        no_idle = 1'b0;
      end
      if (sets_sent == 300) drain();
      random_set();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d points in %0d sets over %0d segment settings", points_sent,
             sets_sent, seg_settings);
    $display("checked %0d clearance results", results);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
